>>> hdl/marching_squares_contour_stream_assert.svh
// assertion macros for the contour stream block
`ifndef MARCHING_SQUARES_CONTOUR_STREAM_ASSERT_SVH
`define MARCHING_SQUARES_CONTOUR_STREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSC_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define MSC_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define MSC_ASSERT_IMP(label, clk, rst, a, b)
`define MSC_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

>>> hdl/msc_pkg.sv
//------------------------------------------------------------------------------
// msc_pkg
// shared types and constants of the contour stream block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package msc_pkg;
   localparam int CFG_BITS = 16;
   localparam logic [1:0] REG_ISO = 2'd0;
   localparam logic [1:0] REG_WIDTH = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam int DIM_BITS = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int COORD_BITS = 20;

   // cell edges, measured from the first corner of each
   localparam logic [2:0] E_LEFT = 3'd0;
   localparam logic [2:0] E_TOP = 3'd1;
   localparam logic [2:0] E_RIGHT = 3'd2;
   localparam logic [2:0] E_BOTTOM = 3'd3;
   localparam logic [2:0] NO_EDGE = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CELL, ST_GO, ST_DIV, ST_STORE, ST_SEND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // take input beat
      logic rd;       // read line store, update counters
      logic classify; // form case, latch cell corners
      logic div_go;   // start division of the current endpoint
      logic store;    // keep quotient as current endpoint
      logic next_pt;  // advance endpoint index
      logic send;     // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;      // cell complete and case emits
      logic div_done;
      logic pt_last;   // endpoint index is the last one
      logic seg_end;   // endpoint index completes a segment
   } sts_type;

   // edges per case, four entries of three bits
   function automatic logic [2:0] case_edge(input logic [3:0] code, input logic [1:0] k);
      logic [11:0] row;
      begin
         case (code)
            4'd1, 4'd14: row = {NO_EDGE, NO_EDGE, E_BOTTOM, E_LEFT};
            4'd2, 4'd13: row = {NO_EDGE, NO_EDGE, E_BOTTOM, E_RIGHT};
            4'd3, 4'd12: row = {NO_EDGE, NO_EDGE, E_RIGHT, E_LEFT};
            4'd4, 4'd11: row = {NO_EDGE, NO_EDGE, E_RIGHT, E_TOP};
            4'd5:        row = {E_RIGHT, E_TOP, E_BOTTOM, E_LEFT};
            4'd6, 4'd9:  row = {NO_EDGE, NO_EDGE, E_BOTTOM, E_TOP};
            4'd7, 4'd8:  row = {NO_EDGE, NO_EDGE, E_TOP, E_LEFT};
            4'd10:       row = {E_BOTTOM, E_RIGHT, E_TOP, E_LEFT};
            default:     row = {NO_EDGE, NO_EDGE, NO_EDGE, NO_EDGE};
         endcase
         case_edge = row[k*3 +: 3];
      end
   endfunction
endpackage

>>> hdl/msc_ctrl.sv
//------------------------------------------------------------------------------
// msc_ctrl
// sequencer for one pixel: read, classify, divide each endpoint, send
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "marching_squares_contour_stream_assert.svh"
module msc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic             out_free,
   input  msc_pkg::sts_type sts,
   output msc_pkg::cmd_type cmd
);
   import msc_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (in_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_CELL;
         ST_CELL:  state_in = sts.emit ? ST_GO : ST_IDLE;
         ST_GO:    state_in = ST_DIV;
         ST_DIV:   if (sts.div_done) state_in = ST_STORE;
         ST_STORE: state_in = sts.seg_end ? ST_SEND : ST_GO;
         ST_SEND:  if (out_free) state_in = sts.pt_last ? ST_IDLE : ST_GO;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin in_ready = 1'b1; cmd.accept = in_valid; end
         ST_READ:  cmd.rd = 1'b1;
         ST_CELL:  cmd.classify = 1'b1;
         ST_GO:    cmd.div_go = 1'b1;
         ST_DIV:   ;
         ST_STORE: begin
            cmd.store = 1'b1;
            cmd.next_pt = !sts.seg_end;
         end
         ST_SEND:  begin
            cmd.send = out_free;
            cmd.next_pt = out_free && !sts.pt_last;
         end
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   `MSC_ASSERT_NXT(a_acc_read, clock, reset, cmd.accept, state_ff == ST_READ)
   `MSC_ASSERT_IMP(a_rdy_idle, clock, reset, in_ready, state_ff == ST_IDLE)
   `MSC_ASSERT_IMP(a_send_free, clock, reset, cmd.send, out_free)
endmodule

>>> hdl/msc_div.sv
//------------------------------------------------------------------------------
// msc_div
// restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "marching_squares_contour_stream_assert.svh"
module msc_div #(
   parameter int NUM_BITS = 17,
   parameter int Q_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [NUM_BITS-1:0] num,
   input  logic [NUM_BITS-1:0] den,
   output logic                done,
   output logic [Q_BITS-1:0]   quot
);
   localparam int CNT_BITS = $clog2(Q_BITS + 1);
   localparam int REM_BITS = NUM_BITS + 1;

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] den_ff;
   logic [Q_BITS-1:0]   q_ff, q_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [REM_BITS-1:0] trial;

   // one shift-subtract step; quotient is (num << Q_BITS-1) / den
   always_comb begin
      trial = {rem_ff[REM_BITS-2:0], 1'b0};
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (go) begin
         rem_in = {1'b0, num};
         q_in = '0;
         cnt_in = CNT_BITS'(Q_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_BITS'(Q_BITS)) begin
            // first step: plain compare, no shift
            trial = rem_ff;
         end
         if (den_ff != '0 && trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[Q_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      if (go) den_ff <= den;
   end

   assign done = !busy_ff && !go && cnt_ff == '0;
   assign quot = q_ff;

   `MSC_ASSERT_NXT(a_go_busy, clock, reset, go, busy_ff)
   `MSC_ASSERT_IMP(a_cnt_range, clock, reset, busy_ff, cnt_ff != '0)
endmodule

>>> hdl/msc_dp.sv
//------------------------------------------------------------------------------
// msc_dp
// line store, counters, case code, endpoint setup and output register
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_dp #(
   parameter int MAX_WIDTH = 4096,
   parameter int PIXEL_BITS = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  msc_pkg::cmd_type               cmd,
   output msc_pkg::sts_type               sts,
   input  logic [PIXEL_BITS-1:0]          in_pixel,
   input  logic                           in_sof,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_idx,
   input  logic [msc_pkg::CFG_BITS-1:0]   csr_data,
   output logic                           out_valid,
   input  logic                           out_taken,
   output logic [4*msc_pkg::COORD_BITS+3:0] out_data,
   output logic                           out_last
);
   import msc_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HW = $clog2(MAX_HEIGHT);
   // distances cover both the pixel and the threshold width
   localparam int WB = ((PIXEL_BITS > CFG_BITS) ? PIXEL_BITS : CFG_BITS) + 1;
   localparam int QB = FRAC_BITS + 1;
   localparam logic [COORD_BITS-1:0] ONE_PX = COORD_BITS'(1 << FRAC_BITS);

   logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
   logic [CFG_BITS-1:0] iso_ff;
   logic [DIM_BITS-1:0] wid_ff, hgt_ff;
   logic [AW-1:0] col_ff;
   logic [HW-1:0] row_ff;
   logic [PIXEL_BITS-1:0] pix_ff, top_ff, left_ff, ul_ff;
   logic [PIXEL_BITS-1:0] tl_ff, tr_ff, bl_ff, br_ff;
   logic sof_ff;
   logic [3:0] code_ff;
   logic [AW-1:0] cx_ff;
   logic [HW-1:0] cy_ff;
   logic emit_ff;
   logic [1:0] pt_ff;
   logic [2:0] edge_ff;
   logic [COORD_BITS-1:0] px_ff [2];
   logic [COORD_BITS-1:0] py_ff [2];
   logic [4*COORD_BITS+3:0] od_ff;
   logic ov_ff, ol_ff;

   logic [WB-1:0] iso_x;
   logic [AW:0] w_sat;
   logic [HW:0] h_sat;
   logic [AW-1:0] c_eff;
   logic [HW-1:0] r_eff;
   logic [3:0] code_now;
   logic [2:0] edge_cur;
   logic [PIXEL_BITS-1:0] ca, cb;
   logic [WB-1:0] w1, w2, den;
   logic div_done;
   logic [QB-1:0] quot;
   logic [COORD_BITS-1:0] fr, bx, by, nx, ny;
   logic pt_last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= 16'd32768;
         wid_ff <= DIM_BITS'(640);
         hgt_ff <= DIM_BITS'(480);
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_ISO:    iso_ff <= csr_data;
            REG_WIDTH:  wid_ff <= csr_data[DIM_BITS-1:0];
            REG_HEIGHT: hgt_ff <= csr_data[DIM_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // saturated geometry
   always_comb begin
      if (wid_ff < DIM_BITS'(2)) w_sat = (AW+1)'(2);
      else if (32'(wid_ff) > MAX_WIDTH) w_sat = (AW+1)'(MAX_WIDTH);
      else w_sat = (AW+1)'(wid_ff);
      if (hgt_ff < DIM_BITS'(2)) h_sat = (HW+1)'(2);
      else if (32'(hgt_ff) > MAX_HEIGHT) h_sat = (HW+1)'(MAX_HEIGHT);
      else h_sat = (HW+1)'(hgt_ff);
      c_eff = sof_ff ? '0 : col_ff;
      r_eff = sof_ff ? '0 : row_ff;
      iso_x = WB'(iso_ff);
   end

   // input capture and line store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= in_pixel;
         sof_ff <= in_sof;
      end
      if (cmd.rd) begin
         top_ff <= mem[c_eff];
         mem[c_eff] <= pix_ff;
      end
   end

   // corner pattern, top-left 8, top-right 4, bottom-right 2, bottom-left 1
   assign code_now = {WB'(ul_ff) <= iso_x, WB'(top_ff) <= iso_x,
                      WB'(pix_ff) <= iso_x, WB'(left_ff) <= iso_x};

   // counters and neighbor pixels
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         ul_ff <= '0;
         emit_ff <= 1'b0;
      end else if (cmd.rd) begin
         cx_ff <= c_eff - 1'b1;
         cy_ff <= r_eff - 1'b1;
         emit_ff <= c_eff != '0 && r_eff != '0;
         if ((AW+1)'(c_eff) >= w_sat - 1'b1) begin
            col_ff <= '0;
            row_ff <= ((HW+1)'(r_eff) >= h_sat - 1'b1) ? '0 : r_eff + 1'b1;
         end else begin
            col_ff <= c_eff + 1'b1;
            row_ff <= r_eff;
         end
      end else if (cmd.classify) begin
         ul_ff <= top_ff;
         left_ff <= pix_ff;
      end
   end

   // cell in work: case, corners and endpoint index
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         code_ff <= code_now;
         tl_ff <= ul_ff;
         tr_ff <= top_ff;
         bl_ff <= left_ff;
         br_ff <= pix_ff;
         pt_ff <= '0;
      end else if (cmd.next_pt) begin
         pt_ff <= pt_ff + 1'b1;
      end
      if (cmd.div_go) edge_ff <= edge_cur;
   end

   // corners of the current endpoint edge and interpolation weights
   always_comb begin
      edge_cur = case_edge(code_ff, pt_ff);
      case (edge_cur)
         E_LEFT:  begin ca = tl_ff; cb = bl_ff; end
         E_TOP:   begin ca = tl_ff; cb = tr_ff; end
         E_RIGHT: begin ca = tr_ff; cb = br_ff; end
         default: begin ca = bl_ff; cb = br_ff; end
      endcase
      w1 = (WB'(ca) > iso_x) ? WB'(ca) - iso_x : iso_x - WB'(ca);
      w2 = (WB'(cb) > iso_x) ? WB'(cb) - iso_x : iso_x - WB'(cb);
      den = w1 + w2;
   end

   msc_div #(.NUM_BITS(WB), .Q_BITS(QB)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (cmd.div_go),
      .num   (w1),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   // endpoint position from edge and quotient
   always_comb begin
      fr = COORD_BITS'(quot);
      bx = COORD_BITS'({cx_ff, {FRAC_BITS{1'b0}}});
      by = COORD_BITS'({cy_ff, {FRAC_BITS{1'b0}}});
      nx = bx;
      ny = by;
      case (edge_ff)
         E_LEFT: ny = by + fr;
         E_TOP:  nx = bx + fr;
         E_RIGHT: begin
            nx = bx + ONE_PX;
            ny = by + fr;
         end
         default: begin
            ny = by + ONE_PX;
            nx = bx + fr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         px_ff[pt_ff[0]] <= nx;
         py_ff[pt_ff[0]] <= ny;
      end
   end

   assign pt_last = (pt_ff == 2'd3) || (case_edge(code_ff, 2'd2) == NO_EDGE);

   // output register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (cmd.send) ov_ff <= 1'b1;
      else if (out_taken) ov_ff <= 1'b0;
      if (cmd.send) begin
         od_ff <= {code_ff, py_ff[1], px_ff[1], py_ff[0], px_ff[0]};
         ol_ff <= pt_last;
      end
   end

   assign sts.emit = emit_ff && code_now != 4'd0 && code_now != 4'd15;
   assign sts.div_done = div_done;
   assign sts.seg_end = pt_ff[0];
   assign sts.pt_last = pt_last;
   assign out_valid = ov_ff;
   assign out_data = od_ff;
   assign out_last = ol_ff;
endmodule

>>> hdl/marching_squares_contour_stream.sv
// each accepted pixel is read and classified; each endpoint of its segments is then
//   divided in turn by the shared serial divider, and a saddle cell sends a second beat
// a new pixel is taken only after the previous one and all its segments are sent, so
//   output stalls hold back the input too
// reset: synchronous, active high; counters, state, left pixels, configuration and output
//   valid take their reset values, other data registers and line store contents stay undefined
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// marching_squares_contour_stream
// isoline segment extractor over a raster pixel stream
//------------------------------------------------------------------------------
module marching_squares_contour_stream #(
   parameter int MAX_WIDTH = 4096,
   parameter int PIXEL_BITS = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_BITS-1:0] req_tdata,   // pixel
   input  logic                  req_tuser,   // start_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [87:0]           rsp_tdata,   // start_x, start_y, end_x, end_y, cell_case
   output logic                  rsp_tlast,   // last_segment
   input  logic                  csr_we,
   input  logic [1:0]            csr_idx,
   input  logic [15:0]           csr_data
);
   import msc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [4*COORD_BITS+3:0] data;
   logic out_free;

   assign out_free = !rsp_tvalid || rsp_tready;

   msc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .out_free (out_free),
      .sts      (sts),
      .cmd      (cmd)
   );

   msc_dp #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_pixel  (req_tdata),
      .in_sof    (req_tuser),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_data  (csr_data),
      .out_valid (rsp_tvalid),
      .out_taken (rsp_tready),
      .out_data  (data),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, data};
endmodule
